// ----- src/bcde_pkg.sv -----
// Shared types, register indexes, reset values and the BCD digit roll
// for the button calibration digit editor. No dependencies.
package bcde_pkg;

    localparam int DIGITS_DEF = 8;
    // Digit selector width covers the full parameter range of up to 16 digits.
    localparam int SEL_W = 4;
    localparam logic [4:0] CNT_MAX = 5'd31;

    localparam logic [9:0]  DEBOUNCE_MS_RST      = 10'd50;
    localparam logic [3:0]  DEBOUNCE_SAMPLES_RST = 4'd3;
    localparam logic [15:0] ENTER_HOLD_MS_RST    = 16'd2000;
    localparam logic [15:0] SAVE_HOLD_MS_RST     = 16'd2000;
    localparam logic [31:0] LOADED_FACTOR_RST    = 32'h0228_0000;

    typedef enum logic [1:0] {
        BUZZ_NONE  = 2'd0,
        BUZZ_SHORT = 2'd1,
        BUZZ_LONG  = 2'd2
    } t_buzz;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE_MS      = 3'd0,
        CFG_DEBOUNCE_SAMPLES = 3'd1,
        CFG_ENTER_HOLD_MS    = 3'd2,
        CFG_SAVE_HOLD_MS     = 3'd3,
        CFG_LOADED_FACTOR    = 3'd4
    } t_cfg_idx;

    // Roll one BCD digit up or down; digits 10..15 count as 9.
    // Digits at position 8 and above have no nibble and are left alone.
    function automatic logic [31:0] roll_digit(input logic [31:0] bcd,
                                               input logic [SEL_W-1:0] sel,
                                               input logic up);
        logic [4:0]  sh;
        logic [3:0]  nib;
        logic [31:0] res;
        sh  = {sel[2:0], 2'b00};
        nib = 4'((bcd >> sh) & 32'hF);
        if (nib > 4'd9) nib = 4'd9;
        if (up) nib = (nib == 4'd9) ? 4'd0 : nib + 4'd1;
        else    nib = (nib == 4'd0) ? 4'd9 : nib - 4'd1;
        res = (bcd & ~(32'hF << sh)) | ({28'd0, nib} << sh);
        if (sel >= SEL_W'(8)) res = bcd;
        return res;
    endfunction

endpackage

// ----- src/button_calibration_digit_editor.sv -----
// Top level of the button calibration digit editor: accepted levels, mode,
// digit editing, long-press handling and the result register.
// Uses bcde_pkg and bcde_debounce.
//
//  channel   direction  handshake                 word
//  input     in         i_valid / o_ready         now_ms + three raw levels
//  result    out        o_valid / i_ready         mode, digit, factors, buzz
//  config    in         i_cfg_valid / o_cfg_ready register index + data
//
// One sample is taken per cycle while o_ready is high; its result appears in
// the result register on the next cycle. Throughput is one word per clock,
// limited only by result back-pressure. Reset is synchronous; the register file
// returns to its defaults. A stalled result holds the input off only while
// the result register is full and not being drained. Config is always ready.
module button_calibration_digit_editor #(
    parameter int DIGITS = bcde_pkg::DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_now_ms,
    input  logic        i_select_level,
    input  logic        i_up_level,
    input  logic        i_down_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_calibrating,
    output logic [2:0]  o_digit_index,
    output logic [31:0] o_edit_factor,
    output logic [31:0] o_active_factor,
    output logic [1:0]  o_buzz_code,
    output logic        o_save_strobe,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bcde_pkg::*;

    localparam logic [SEL_W:0] DIGITS_LIM = (SEL_W+1)'(DIGITS);

    // config registers
    logic [9:0]  r_debounce_ms;
    logic [3:0]  r_debounce_samples;
    logic [15:0] r_enter_hold_ms;
    logic [15:0] r_save_hold_ms;

    // editor state
    logic             r_mode;
    logic [SEL_W-1:0] r_sel;
    logic [31:0]      r_edit;
    logic [31:0]      r_active;
    logic             r_acc_sel;
    logic             r_acc_up;
    logic             r_acc_down;
    logic [31:0]      r_press_start;
    logic             r_hold_used;

    logic             n_mode;
    logic [SEL_W-1:0] n_sel;
    logic [31:0]      n_edit;
    logic [31:0]      n_active;
    logic             n_acc_sel;
    logic             n_acc_up;
    logic             n_acc_down;
    logic [31:0]      n_press_start;
    logic             n_hold_used;
    t_buzz            n_buzz;
    logic             n_strobe;

    // result register
    logic        r_out_valid;
    logic        r_o_mode;
    logic [2:0]  r_o_sel;
    logic [31:0] r_o_edit;
    logic [31:0] r_o_active;
    t_buzz       r_o_buzz;
    logic        r_o_strobe;

    logic        w_accept;
    logic        w_cfg_wr;
    logic        w_ok_sel;
    logic        w_ok_up;
    logic        w_ok_down;
    logic [31:0] w_held;

    assign o_ready     = !r_out_valid || i_ready;
    assign w_accept    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    bcde_debounce u_db_sel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_accept), .i_now_ms(i_now_ms),
        .i_raw(i_select_level), .i_debounce_ms(r_debounce_ms),
        .i_debounce_samples(r_debounce_samples), .o_stable(w_ok_sel)
    );
    bcde_debounce u_db_up (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_accept), .i_now_ms(i_now_ms),
        .i_raw(i_up_level), .i_debounce_ms(r_debounce_ms),
        .i_debounce_samples(r_debounce_samples), .o_stable(w_ok_up)
    );
    bcde_debounce u_db_down (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_accept), .i_now_ms(i_now_ms),
        .i_raw(i_down_level), .i_debounce_ms(r_debounce_ms),
        .i_debounce_samples(r_debounce_samples), .o_stable(w_ok_down)
    );

    assign w_held = i_now_ms - r_press_start;

    always_comb begin
        n_mode        = r_mode;
        n_sel         = r_sel;
        n_edit        = r_edit;
        n_active      = r_active;
        n_acc_sel     = r_acc_sel;
        n_acc_up      = r_acc_up;
        n_acc_down    = r_acc_down;
        n_press_start = r_press_start;
        n_hold_used   = r_hold_used;
        n_buzz        = BUZZ_NONE;
        n_strobe      = 1'b0;

        // up before down, both before select
        if (w_ok_up && (i_up_level != r_acc_up)) begin
            n_acc_up = i_up_level;
            if (!i_up_level && r_mode) begin
                n_edit = roll_digit(n_edit, r_sel, 1'b1);
                n_buzz = BUZZ_SHORT;
            end
        end
        if (w_ok_down && (i_down_level != r_acc_down)) begin
            n_acc_down = i_down_level;
            if (!i_down_level && r_mode) begin
                n_edit = roll_digit(n_edit, r_sel, 1'b0);
                n_buzz = BUZZ_SHORT;
            end
        end

        if (w_ok_sel) begin
            if (i_select_level != r_acc_sel) begin
                n_acc_sel = i_select_level;
                if (!i_select_level) begin
                    n_press_start = i_now_ms;
                end else if (r_hold_used) begin
                    n_hold_used = 1'b0;
                end else begin
                    if (r_mode) begin
                        n_sel = (({1'b0, r_sel} + 1'b1) >= DIGITS_LIM) ?
                                '0 : r_sel + 1'b1;
                    end
                    n_buzz = BUZZ_SHORT;
                end
            end else if (!r_acc_sel && !r_hold_used) begin
                if (r_mode) begin
                    if (w_held > {16'd0, r_save_hold_ms}) begin
                        n_active    = n_edit;
                        n_mode      = 1'b0;
                        n_strobe    = 1'b1;
                        n_buzz      = BUZZ_LONG;
                        n_hold_used = 1'b1;
                    end
                end else if (w_held > {16'd0, r_enter_hold_ms}) begin
                    n_mode      = 1'b1;
                    n_sel       = '0;
                    n_edit      = r_active;
                    n_buzz      = BUZZ_LONG;
                    n_hold_used = 1'b1;
                end
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms      <= DEBOUNCE_MS_RST;
            r_debounce_samples <= DEBOUNCE_SAMPLES_RST;
            r_enter_hold_ms    <= ENTER_HOLD_MS_RST;
            r_save_hold_ms     <= SAVE_HOLD_MS_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS:      r_debounce_ms      <= i_cfg_data[9:0];
                CFG_DEBOUNCE_SAMPLES: r_debounce_samples <= i_cfg_data[3:0];
                CFG_ENTER_HOLD_MS:    r_enter_hold_ms    <= i_cfg_data[15:0];
                CFG_SAVE_HOLD_MS:     r_save_hold_ms     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // editor state; a factor load from config overrides the edit path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_sel         <= '0;
            r_edit        <= LOADED_FACTOR_RST;
            r_active      <= LOADED_FACTOR_RST;
            r_acc_sel     <= 1'b1;
            r_acc_up      <= 1'b1;
            r_acc_down    <= 1'b1;
            r_press_start <= '0;
            r_hold_used   <= 1'b0;
        end else if (w_cfg_wr && (i_cfg_index == CFG_LOADED_FACTOR)) begin
            r_edit   <= i_cfg_data;
            r_active <= i_cfg_data;
        end else if (w_accept) begin
            r_mode        <= n_mode;
            r_sel         <= n_sel;
            r_edit        <= n_edit;
            r_active      <= n_active;
            r_acc_sel     <= n_acc_sel;
            r_acc_up      <= n_acc_up;
            r_acc_down    <= n_acc_down;
            r_press_start <= n_press_start;
            r_hold_used   <= n_hold_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_o_mode   <= n_mode;
            r_o_sel    <= n_sel[2:0];
            r_o_edit   <= n_edit;
            r_o_active <= n_active;
            r_o_buzz   <= n_buzz;
            r_o_strobe <= n_strobe;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_calibrating   = r_o_mode;
    assign o_digit_index   = r_o_sel;
    assign o_edit_factor   = r_o_edit;
    assign o_active_factor = r_o_active;
    assign o_buzz_code     = r_o_buzz;
    assign o_save_strobe   = r_o_strobe;

    // a commit always leaves the mode with a long buzz
    a_strobe_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_save_strobe) |-> (!o_calibrating && o_buzz_code == BUZZ_LONG))
        else $error("save strobe without mode exit and long buzz");

    // a committed word carries equal edit and active factors
    a_strobe_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_save_strobe) |-> (o_active_factor == o_edit_factor))
        else $error("committed factor differs from edited factor");

    // a hold that takes effect is reported by a long buzz in the same word
    a_hold_buzz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hold_used) |-> (o_valid && o_buzz_code == BUZZ_LONG))
        else $error("hold action without long buzz");

endmodule

// ----- src/bcde_debounce.sv -----
// Debounce tracker for one active-low button: candidate level, change time
// and saturating sample count. Uses bcde_pkg.
module bcde_debounce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [31:0] i_now_ms,
    input  logic        i_raw,
    input  logic [9:0]  i_debounce_ms,
    input  logic [3:0]  i_debounce_samples,
    output logic        o_stable
);
    import bcde_pkg::*;

    logic        r_cand;
    logic [31:0] r_change_time;
    logic [4:0]  r_count;
    logic [31:0] n_change_time;
    logic [4:0]  n_count;
    logic [4:0]  w_count;
    logic        w_diff;
    logic [31:0] w_age;

    always_comb begin
        w_diff        = (i_raw != r_cand);
        n_change_time = w_diff ? i_now_ms : r_change_time;
        w_count       = w_diff ? 5'd0 : r_count;
        n_count       = (w_count < CNT_MAX) ? w_count + 5'd1 : w_count;
        w_age         = i_now_ms - n_change_time;
        o_stable      = (w_age > {22'd0, i_debounce_ms}) &&
                        (n_count > {1'b0, i_debounce_samples});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand        <= 1'b1;
            r_change_time <= '0;
            r_count       <= '0;
        end else if (i_en) begin
            r_cand        <= i_raw;
            r_change_time <= n_change_time;
            r_count       <= n_count;
        end
    end

endmodule
